### hw/rtl/touch_region_gesture_classifier_unit_defines.svh
// Assertion macros used by the classifier controller.
`ifndef TOUCH_REGION_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH
`define TOUCH_REGION_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH
// Check that a condition implies a consequence on the same edge.
`define TRG_ASSERT_IMP(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Check that a condition implies a consequence on the next edge.
`define TRG_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

### hw/rtl/trgc_pkg.sv
// Package: shared types and codes of the touch region classifier.
`timescale 1ns / 1ps
package trgc_pkg;
    localparam int unsigned FUNC_BITS = 3;
    localparam int unsigned KIND_BITS = 3;
    localparam int unsigned TAG_BITS  = 16;
    localparam int unsigned TICK_BITS = 32;
    localparam int unsigned CFG_BITS  = 16;
    localparam int unsigned SLOT_BITS = 3;

    localparam logic [2:0] FN_SAMPLE = 3'd0;
    localparam logic [2:0] FN_REG    = 3'd1;
    localparam logic [2:0] FN_POS    = 3'd2;
    localparam logic [2:0] FN_UNREG  = 3'd3;
    localparam logic [2:0] FN_IDLE   = 3'd4;
    localparam logic [2:0] FN_CLEAR  = 3'd5;

    localparam logic [2:0] MD_UP    = 3'd0;
    localparam logic [2:0] MD_PROBE = 3'd1;
    localparam logic [2:0] MD_SHORT = 3'd2;
    localparam logic [2:0] MD_LONG  = 3'd3;
    localparam logic [2:0] MD_MOVE  = 3'd4;
    localparam logic [2:0] MD_IDLE  = 3'd5;

    localparam logic [1:0] TS_UP    = 2'd0;
    localparam logic [1:0] TS_SHORT = 2'd1;
    localparam logic [1:0] TS_LONG  = 2'd2;
    localparam logic [1:0] TS_MOVE  = 2'd3;

    localparam logic [2:0] EV_UP    = 3'd0;
    localparam logic [2:0] EV_SHORT = 3'd1;
    localparam logic [2:0] EV_MOVE  = 3'd2;
    localparam logic [2:0] EV_LDOWN = 3'd3;
    localparam logic [2:0] EV_LPRESS = 3'd4;
    localparam logic [2:0] EV_NONE  = 3'd7;  // no follow-up event held

    localparam logic [1:0] RG_DEBOUNCE = 2'd0;
    localparam logic [1:0] RG_LONG     = 2'd1;
    localparam logic [1:0] RG_REPEAT   = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;   // capture the accepted item and apply non-sample functions
        logic start;  // open a sample: decide mode, reset slot pointer
        logic visit;  // evaluate current slot, maybe hold an event
        logic second; // the held slot has a follow-up event
        logic adv;    // advance slot pointer
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic walk;    // sample needs a slot walk
        logic done;    // pointer past the last slot
        logic emit1;   // current slot emits a first event
        logic emit2;   // current slot emits a follow-up event
        logic stop;    // walk stops after this slot
    } t_sts;
endpackage

### hw/rtl/trgc_if.sv
// Valid/ready channel interface.
`timescale 1ns / 1ps
interface trgc_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/trgc_ctrl.sv
// Controller: sequences load, slot walk and event transfers.
`timescale 1ns / 1ps
`include "touch_region_gesture_classifier_unit_defines.svh"
module trgc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_func_sample,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output trgc_pkg::t_cmd  o_cmd,
    input  trgc_pkg::t_sts  i_sts
);
    import trgc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_VISIT = 5'b00100,
        S_OUT1  = 5'b01000,
        S_OUT2  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_stop, n_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stop  <= n_stop;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT1) || (r_state == S_OUT2);

    always_comb begin
        n_state = r_state;
        n_stop  = r_stop;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_func_sample) n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state = i_sts.walk ? S_VISIT : S_IDLE;
            end
            S_VISIT: begin
                if (i_sts.done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.visit = 1'b1;
                    n_stop = i_sts.stop;
                    if (i_sts.emit1) n_state = S_OUT1;
                    else o_cmd.adv = 1'b1;
                end
            end
            S_OUT1: begin
                if (i_out_ready) begin
                    if (i_sts.emit2) begin
                        o_cmd.second = 1'b1;
                        n_state = S_OUT2;
                    end else begin
                        o_cmd.adv = 1'b1;
                        n_state = r_stop ? S_IDLE : S_VISIT;
                    end
                end
            end
            S_OUT2: begin
                if (i_out_ready) begin
                    o_cmd.adv = 1'b1;
                    n_state = S_VISIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `TRG_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, o_out_valid, !o_in_ready, "accept while busy")
    `TRG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "event dropped")
    `TRG_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0({o_cmd.load, o_cmd.start, o_cmd.visit}), "command clash")
endmodule

### hw/rtl/trgc_dp.sv
// Datapath: region table, gesture mode, reference tick and event register.
`timescale 1ns / 1ps
module trgc_dp #(
    parameter int unsigned NUM_REGIONS = 8,
    parameter int unsigned COORD_BITS  = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  trgc_pkg::t_cmd                 i_cmd,
    output trgc_pkg::t_sts                 o_sts,
    input  logic [2:0]                     i_func,
    input  logic [COORD_BITS-1:0]          i_touch_x,
    input  logic [COORD_BITS-1:0]          i_touch_y,
    input  logic [31:0]                    i_now_tick,
    input  logic [2:0]                     i_slot,
    input  logic [COORD_BITS-1:0]          i_region_left,
    input  logic [COORD_BITS-1:0]          i_region_top,
    input  logic [COORD_BITS-1:0]          i_region_width,
    input  logic [COORD_BITS-1:0]          i_region_height,
    input  logic [15:0]                    i_region_tag,
    input  logic [15:0]                    i_debounce,
    input  logic [15:0]                    i_long,
    input  logic [15:0]                    i_repeat,
    output logic [15:0]                    o_event_tag,
    output logic [2:0]                     o_event_kind,
    output logic [COORD_BITS-1:0]          o_event_x,
    output logic [COORD_BITS-1:0]          o_event_y,
    output logic                           o_last
);
    import trgc_pkg::*;

    localparam int unsigned IB = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int unsigned PB = $clog2(NUM_REGIONS + 1);

    logic [NUM_REGIONS-1:0]  r_active;
    logic [COORD_BITS-1:0]   r_left [NUM_REGIONS];
    logic [COORD_BITS-1:0]   r_top  [NUM_REGIONS];
    logic [COORD_BITS-1:0]   r_wid  [NUM_REGIONS];
    logic [COORD_BITS-1:0]   r_hgt  [NUM_REGIONS];
    logic [15:0]             r_tag  [NUM_REGIONS];
    logic [1:0]              r_touch [NUM_REGIONS];
    logic [2:0]              r_mode;
    logic [31:0]             r_ref;
    logic [COORD_BITS-1:0]   r_x, r_y;
    logic [31:0]             r_now;
    logic [2:0]              r_walk;   // mode used for the walk
    logic [PB-1:0]           r_ptr;
    logic [2:0]              r_kind2;
    logic [15:0]             r_etag;
    logic [2:0]              r_ekind;
    logic                    r_elast;

    logic [IB-1:0]           w_idx;
    logic                    w_in;
    logic [COORD_BITS:0]     w_re, w_be;
    logic                    w_hit, w_elig, w_fire2, w_stop;
    logic [31:0]             w_el;
    logic [16:0]             w_lr;
    logic [1:0]              w_ntouch;
    logic [2:0]              w_k1, w_k2;
    logic [NUM_REGIONS-1:0]  w_later;
    logic                    w_any_later;
    logic                    w_slot_ok;
    logic                    w_rel;

    assign w_idx  = r_ptr[IB-1:0];
    assign w_in   = (r_ptr < PB'(NUM_REGIONS));
    assign w_re   = {1'b0, r_left[w_idx]} + {1'b0, r_wid[w_idx]};
    assign w_be   = {1'b0, r_top[w_idx]} + {1'b0, r_hgt[w_idx]};
    assign w_hit  = (r_left[w_idx] < r_x) && ({1'b0, r_x} < w_re) &&
                    (r_top[w_idx] < r_y) && ({1'b0, r_y} < w_be);
    assign w_el   = r_now - r_ref;
    assign w_lr   = {1'b0, i_long} + {1'b0, i_repeat};
    assign w_slot_ok = ({29'd0, i_slot} < 32'(NUM_REGIONS));
    assign w_rel  = (i_touch_x == '0) && (i_touch_y == '0);

    // Per-slot eligibility and actions for the walk mode.
    always_comb begin
        w_elig = 1'b0; w_fire2 = 1'b0; w_stop = 1'b0;
        w_ntouch = r_touch[w_idx]; w_k1 = EV_MOVE; w_k2 = EV_LDOWN;
        case (r_walk)
            MD_UP: begin
                w_elig = r_active[w_idx] && (r_touch[w_idx] != TS_UP);
                w_ntouch = TS_UP; w_k1 = EV_UP;
            end
            MD_PROBE: begin
                w_elig = r_active[w_idx] && w_hit;
                w_ntouch = TS_SHORT; w_k1 = EV_SHORT;
            end
            MD_SHORT: begin
                w_elig = r_active[w_idx] && (r_touch[w_idx] == TS_SHORT);
                w_stop = !w_hit;
                w_fire2 = w_hit && (w_el >= {16'd0, i_long});
                if (w_fire2) w_ntouch = TS_LONG;
            end
            MD_LONG: begin
                w_elig = r_active[w_idx] && (r_touch[w_idx] == TS_LONG);
                w_stop = !w_hit;
                w_fire2 = w_hit && ({1'b0, w_el} >= {16'd0, w_lr});
                w_k2 = EV_LPRESS;
            end
            MD_MOVE: begin
                w_elig = r_active[w_idx] && (r_touch[w_idx] != TS_UP);
                w_ntouch = TS_MOVE;
            end
            default: w_elig = 1'b0;
        endcase
        w_elig = w_elig && w_in;
    end

    // Conservative look-ahead: any later slot that could emit.
    always_comb begin
        for (int i = 0; i < NUM_REGIONS; i++) begin
            w_later[i] = (PB'(i) > r_ptr) && r_active[i] &&
                         ((r_walk == MD_PROBE) ||
                          (r_walk == MD_SHORT && r_touch[i] == TS_SHORT) ||
                          (r_walk == MD_LONG && r_touch[i] == TS_LONG) ||
                          ((r_walk == MD_UP || r_walk == MD_MOVE) && r_touch[i] != TS_UP));
        end
        w_any_later = |w_later;
    end

    // A probe hit on a later slot is only known when visited, so test the hit
    // for each later slot here (independent per slot, narrow compares).
    logic [NUM_REGIONS-1:0] w_later_hit;
    always_comb begin
        for (int i = 0; i < NUM_REGIONS; i++) begin
            w_later_hit[i] = (r_left[i] < r_x) &&
                ({1'b0, r_x} < ({1'b0, r_left[i]} + {1'b0, r_wid[i]})) &&
                (r_top[i] < r_y) &&
                ({1'b0, r_y} < ({1'b0, r_top[i]} + {1'b0, r_hgt[i]}));
        end
    end
    logic w_more;
    assign w_more = (r_walk == MD_PROBE) ? |(w_later & w_later_hit) : w_any_later;

    assign o_sts.walk    = (r_walk != MD_IDLE);
    assign o_sts.done    = !w_in;
    assign o_sts.emit1   = w_elig;
    assign o_sts.emit2   = (r_kind2 != EV_NONE);
    assign o_sts.stop    = w_stop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_mode   <= MD_UP;
            r_ref    <= '0;
            for (int i = 0; i < NUM_REGIONS; i++) begin
                r_left[i] <= '0; r_top[i] <= '0; r_wid[i] <= '0;
                r_hgt[i] <= '0; r_tag[i] <= '0; r_touch[i] <= TS_UP;
            end
            r_walk <= MD_IDLE;
            r_ptr  <= '0;
            r_kind2 <= EV_NONE;
        end else begin
            if (i_cmd.load) begin
                r_x <= i_touch_x; r_y <= i_touch_y; r_now <= i_now_tick;
                case (i_func)
                    FN_SAMPLE: begin
                        if (w_rel) begin
                            r_walk <= MD_UP;
                            r_mode <= MD_UP;
                            r_ref  <= i_now_tick;
                        end else begin
                            r_walk <= r_mode;
                        end
                    end
                    FN_REG: if (w_slot_ok && !r_active[i_slot[IB-1:0]]) begin
                        r_active[i_slot[IB-1:0]] <= 1'b1;
                        r_wid[i_slot[IB-1:0]] <= i_region_width;
                        r_hgt[i_slot[IB-1:0]] <= i_region_height;
                        r_tag[i_slot[IB-1:0]] <= i_region_tag;
                        r_touch[i_slot[IB-1:0]] <= TS_UP;
                    end
                    FN_POS: if (w_slot_ok) begin
                        r_left[i_slot[IB-1:0]] <= i_region_left;
                        r_top[i_slot[IB-1:0]]  <= i_region_top;
                    end
                    FN_UNREG: if (w_slot_ok) r_active[i_slot[IB-1:0]] <= 1'b0;
                    FN_IDLE:  r_mode <= MD_IDLE;
                    FN_CLEAR: begin
                        r_active <= '0;
                        r_mode <= MD_UP;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.start) begin
                r_ptr <= '0;
                case (r_walk)
                    MD_UP: begin
                        if (!((r_x == '0) && (r_y == '0))) begin
                            r_mode <= MD_PROBE;
                            r_ref  <= r_now;
                            r_walk <= MD_IDLE;
                        end
                    end
                    MD_PROBE: begin
                        if (w_el < {16'd0, i_debounce}) r_walk <= MD_IDLE;
                        else r_mode <= MD_SHORT;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.visit && w_elig) begin
                r_touch[w_idx] <= w_ntouch;
                r_etag  <= r_tag[w_idx];
                r_ekind <= w_k1;
                r_elast <= w_stop || !(w_fire2 || w_more);
                r_kind2 <= w_fire2 ? w_k2 : EV_NONE;
                if (w_stop) r_mode <= MD_MOVE;
                else if (w_fire2 && r_walk == MD_SHORT) r_mode <= MD_LONG;
                if (w_fire2 && r_walk == MD_LONG) r_ref <= r_ref + {16'd0, i_repeat};
            end
            if (i_cmd.second) begin
                r_ekind <= r_kind2;
                r_elast <= !w_more;
                r_kind2 <= EV_NONE;
            end
            if (i_cmd.adv) r_ptr <= r_ptr + PB'(1);
        end
    end

    assign o_event_tag  = r_etag;
    assign o_event_kind = r_ekind;
    assign o_event_x    = (r_walk == MD_UP) ? '0 : r_x;
    assign o_event_y    = (r_walk == MD_UP) ? '0 : r_y;
    assign o_last       = r_elast;
endmodule

### hw/rtl/touch_region_gesture_classifier_unit.sv
// Top level: touch region gesture classifier with APB register port.
// Sequence: a non-sample item is applied as it is accepted; a sample is loaded,
//   opened, then walks the region slots one visit at a time, with each event
//   held until taken. Only one item is in flight; a new item is accepted
//   only in idle, after the walk over the region table has finished.
// Reset: i_rst_n synchronous active low; clears all regions, mode up, tick 0,
//   registers to 20 / 1000 / 200.
`timescale 1ns / 1ps
module touch_region_gesture_classifier_unit #(
    parameter int unsigned NUM_REGIONS = 8,
    parameter int unsigned COORD_BITS  = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    trgc_if.sink        i_item,
    trgc_if.source      o_event
);
    import trgc_pkg::*;

    // Input payload layout, most significant first: func, x, y, tick, slot,
    // left, top, width, height, tag.
    localparam int unsigned IW = 3 + 2*COORD_BITS + 32 + 3 + 4*COORD_BITS + 16;

    logic [2:0]            w_func;
    logic [COORD_BITS-1:0] w_x, w_y, w_l, w_t, w_w, w_h, w_ex, w_ey;
    logic [31:0]           w_now;
    logic [2:0]            w_slot, w_kind;
    logic [15:0]           w_tag, w_etag;
    logic                  w_last;
    t_cmd                  w_cmd;
    t_sts                  w_sts;

    assign {w_func, w_x, w_y, w_now, w_slot, w_l, w_t, w_w, w_h, w_tag} = i_item.data[IW-1:0];

    // Configuration registers; write on the access phase.
    logic [15:0] r_deb, r_long, r_rep;
    logic [1:0]  w_ridx;
    assign w_ridx = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb  <= 16'd20;
            r_long <= 16'd1000;
            r_rep  <= 16'd200;
        end else if (psel && penable && pwrite) begin
            unique case (w_ridx)
                RG_DEBOUNCE: r_deb  <= pwdata[15:0];
                RG_LONG:     r_long <= pwdata[15:0];
                RG_REPEAT:   r_rep  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_ridx)
            RG_DEBOUNCE: prdata = {16'd0, r_deb};
            RG_LONG:     prdata = {16'd0, r_long};
            RG_REPEAT:   prdata = {16'd0, r_rep};
            default:     prdata = '0;
        endcase
    end

    trgc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_item.valid),
        .o_in_ready    (i_item.ready),
        .i_func_sample (w_func == FN_SAMPLE),
        .o_out_valid   (o_event.valid),
        .i_out_ready   (o_event.ready),
        .o_cmd         (w_cmd),
        .i_sts         (w_sts)
    );

    trgc_dp #(.NUM_REGIONS(NUM_REGIONS), .COORD_BITS(COORD_BITS)) u_dp (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_cmd (w_cmd), .o_sts (w_sts),
        .i_func (w_func), .i_touch_x (w_x), .i_touch_y (w_y), .i_now_tick (w_now),
        .i_slot (w_slot), .i_region_left (w_l), .i_region_top (w_t),
        .i_region_width (w_w), .i_region_height (w_h), .i_region_tag (w_tag),
        .i_debounce (r_deb), .i_long (r_long), .i_repeat (r_rep),
        .o_event_tag (w_etag), .o_event_kind (w_kind), .o_event_x (w_ex),
        .o_event_y (w_ey), .o_last (w_last)
    );

    // Output payload: tag, kind, x, y, last.
    assign o_event.data = {w_etag, w_kind, w_ex, w_ey, w_last};
endmodule
